// ===== rtl/core/psm_pkg.sv =====
`timescale 1ns / 1ps
// psm_pkg: shared widths, constants and bundle types of the periodic source merger
// no dependencies; imported by every module of the block

package psm_pkg;

    // number of generator slots held by the block (1 .. 8)
    localparam int NUM_SLOTS = 8;

    // fixed field widths
    localparam int CMD_W = 1;
    localparam int SRC_W = 3;
    localparam int VAL_W = 48;
    localparam int PER_W = 32;
    localparam int ACT_W = 4;

    // derived widths
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W  = (CNT_W > ACT_W) ? CNT_W : ACT_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_NEXT = 1'b1;

    // slot store access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic              wr_per;
        logic [SLOT_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_pend;
        logic [PER_W-1:0]  wr_per_data;
        logic [SLOT_W-1:0] rd_addr;
    } t_mem_req;

    // finished result handed to the output register
    typedef struct packed {
        logic             load;
        logic [VAL_W-1:0] value;
        logic [SRC_W-1:0] source;
    } t_result;

endpackage

// ===== rtl/core/psm_slot_ram.sv =====
`timescale 1ns / 1ps
// psm_slot_ram: pending value and period store, one write and one registered read per cycle
// depends on psm_pkg

module psm_slot_ram (
    input  logic                       i_clk,
    input  psm_pkg::t_mem_req          i_req,
    output logic [psm_pkg::VAL_W-1:0]  o_rd_pend,
    output logic [psm_pkg::PER_W-1:0]  o_rd_per
);
    import psm_pkg::*;

    logic [VAL_W-1:0] r_pend [NUM_SLOTS];
    logic [PER_W-1:0] r_per  [NUM_SLOTS];
    logic [VAL_W-1:0] r_rd_pend;
    logic [PER_W-1:0] r_rd_per;

    // contents are undefined until a slot is loaded
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_pend[i_req.wr_addr] <= i_req.wr_pend;
            if (i_req.wr_per) begin
                r_per[i_req.wr_addr] <= i_req.wr_per_data;
            end
        end
        r_rd_pend <= r_pend[i_req.rd_addr];
        r_rd_per  <= r_per[i_req.rd_addr];
    end

    assign o_rd_pend = r_rd_pend;
    assign o_rd_per  = r_rd_per;

endmodule

// ===== rtl/core/psm_ctrl.sv =====
`timescale 1ns / 1ps
// psm_ctrl: sequencer with the shared compare / saturating add unit for the slot scan
// depends on psm_pkg; drives psm_slot_ram

module psm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [psm_pkg::CMD_W-1:0]   i_command,
    input  logic [psm_pkg::SRC_W-1:0]   i_slot,
    input  logic [psm_pkg::PER_W-1:0]   i_first_value,
    input  logic [psm_pkg::PER_W-1:0]   i_step,
    input  logic [psm_pkg::CNT_W-1:0]   i_active_cnt,
    input  logic                        i_out_free,
    input  logic [psm_pkg::VAL_W-1:0]   i_rd_pend,
    input  logic [psm_pkg::PER_W-1:0]   i_rd_per,
    output psm_pkg::t_mem_req           o_mem_req,
    output psm_pkg::t_result            o_result
);
    import psm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state            r_state,    n_state;
    logic [CNT_W-1:0]  r_idx,      n_idx;
    logic              r_cmp_vld,  n_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_idx,  n_cmp_idx;
    logic [VAL_W-1:0]  r_best_val, n_best_val;
    logic [PER_W-1:0]  r_best_per, n_best_per;
    logic [SLOT_W-1:0] r_best_idx, n_best_idx;

    logic             accept;
    logic             issue;
    logic             take;
    logic [VAL_W:0]   sum;
    logic [VAL_W-1:0] sat_sum;

    assign accept = i_valid && (r_state == ST_IDLE);
    assign issue  = (r_idx < i_active_cnt);

    // shared compare: first slot seeds the minimum, ties keep the lower slot
    assign take = r_cmp_vld && ((r_cmp_idx == '0) || (i_rd_pend < r_best_val));

    // shared saturating add, carry out means overflow
    assign sum     = {1'b0, r_best_val} + {{(VAL_W + 1 - PER_W){1'b0}}, r_best_per};
    assign sat_sum = sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_best_val = r_best_val;
        n_best_per = r_best_per;
        n_best_idx = r_best_idx;

        o_mem_req             = '0;
        o_mem_req.rd_addr     = SLOT_W'(r_idx);
        o_result.load         = 1'b0;
        o_result.value        = r_best_val;
        o_result.source       = SRC_W'(r_best_idx);

        if (take) begin
            n_best_val = i_rd_pend;
            n_best_per = i_rd_per;
            n_best_idx = r_cmp_idx;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_NEXT) begin
                        n_state = ST_SCAN;
                        n_idx   = '0;
                    end else if (int'(i_slot) < NUM_SLOTS) begin
                        o_mem_req.wr_en       = 1'b1;
                        o_mem_req.wr_per      = 1'b1;
                        o_mem_req.wr_addr     = SLOT_W'(i_slot);
                        o_mem_req.wr_pend     = VAL_W'(i_first_value);
                        o_mem_req.wr_per_data = i_step;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_idx     = r_idx + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = SLOT_W'(r_idx);
                end else begin
                    // last compare lands at this edge
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    o_result.load     = 1'b1;
                    o_mem_req.wr_en   = 1'b1;
                    o_mem_req.wr_addr = r_best_idx;
                    o_mem_req.wr_pend = sat_sum;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_idx     <= n_idx;
        end
        r_cmp_idx  <= n_cmp_idx;
        r_best_val <= n_best_val;
        r_best_per <= n_best_per;
        r_best_idx <= n_best_idx;
    end

    assign o_stall = (r_state != ST_IDLE);

    // a next word always takes the sequencer out of idle
    a_next_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == CMD_NEXT)) |=> o_stall)
        else $error("next word did not start a scan");

    // a result is only handed over when the output register can take it
    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.load |-> i_out_free)
        else $error("result loaded into a busy output register");

    // the scan index never runs past the active slot count
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= i_active_cnt))
        else $error("scan index beyond active slots");

    // a compare only follows a read issued during the scan
    a_cmp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> $past(r_state == ST_SCAN))
        else $error("compare without a scan read");

endmodule

// ===== rtl/core/periodic_source_merger.sv =====
`timescale 1ns / 1ps
// periodic_source_merger: top level, config register, output register and instances
// depends on psm_pkg, psm_slot_ram, psm_ctrl
//
// usage
//   input channel (i_valid / o_stall) carries command words. a load word
//   (command 0) writes first value and period of one slot; slots at or above
//   the slot count are ignored. a next word (command 1) emits the smallest
//   pending value over slots 0 .. active-1 with its slot number, lowest slot
//   on ties, then advances that slot by its period, saturating at 2^48-1
//   output channel (o_valid / i_stall) carries one word per next word
//   timing: a load word is taken every cycle while the sequencer is idle. a
//   next word scans the slots through one registered read port and one
//   comparator, one slot a cycle, over the active slots (clamped to
//   1 .. NUM_SLOTS), then loads its result once the output register is free;
//   o_stall stays high until then, so no word is taken before that handover
//   reset: synchronous, active low; active slot count returns to 1, slot
//   contents are undefined until loaded
//   stall: a waiting result sits in the output register while load words are
//   still taken; a further next word holds its result until the register frees
//   config: i_cfg_we writes the active slot count; idle-only is the user's rule

module periodic_source_merger (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [psm_pkg::ACT_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [psm_pkg::CMD_W-1:0]   i_command,
    input  logic [psm_pkg::SRC_W-1:0]   i_slot,
    input  logic [psm_pkg::PER_W-1:0]   i_first_value,
    input  logic [psm_pkg::PER_W-1:0]   i_step,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [psm_pkg::VAL_W-1:0]   o_value,
    output logic [psm_pkg::SRC_W-1:0]   o_source
);
    import psm_pkg::*;

    logic [ACT_W-1:0] r_active_slots;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_value;
    logic [SRC_W-1:0] r_source;

    logic [CMP_W-1:0] act_ext;
    logic [CNT_W-1:0] active_cnt;
    logic             out_free;
    t_mem_req         mem_req;
    t_result          result;
    logic [VAL_W-1:0] rd_pend;
    logic [PER_W-1:0] rd_per;

    // clamp the configured count to 1 .. NUM_SLOTS
    assign act_ext = CMP_W'(r_active_slots);
    always_comb begin
        if (act_ext == '0) begin
            active_cnt = CNT_W'(1);
        end else if (act_ext > CMP_W'(NUM_SLOTS)) begin
            active_cnt = CNT_W'(NUM_SLOTS);
        end else begin
            active_cnt = CNT_W'(act_ext);
        end
    end

    // output register frees when empty or when its word is taken this cycle
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= ACT_W'(1);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active_slots <= i_cfg_wdata;
            end
            if (result.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (result.load) begin
            r_value  <= result.value;
            r_source <= result.source;
        end
    end

    psm_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_pend (rd_pend),
        .o_rd_per  (rd_per)
    );

    psm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_slot        (i_slot),
        .i_first_value (i_first_value),
        .i_step        (i_step),
        .i_active_cnt  (active_cnt),
        .i_out_free    (out_free),
        .i_rd_pend     (rd_pend),
        .i_rd_per      (rd_per),
        .o_mem_req     (mem_req),
        .o_result      (result)
    );

    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_source = r_source;

endmodule
